/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    `ASSERT_CLK(label, clk, rst_n, !(expr))

`endif

/* hw/rtl/brlt_pkg.sv */
// Types and constants for the byte-range lock table.
// No dependencies.
`timescale 1ns / 1ps

package brlt_pkg;

    localparam int LOCK_ENTRIES_DEF = 32;
    localparam int FILE_HANDLES_DEF = 16;
    localparam int HANDLE_W_DEF     = 4;
    localparam int ADDR_W           = 32;
    localparam int OWNER_W          = 16;
    localparam int KEY_W            = 16;

    typedef enum logic [1:0] {
        REQ_ACCESS = 2'd0,
        REQ_LOCK   = 2'd1,
        REQ_UNLOCK = 2'd2,
        REQ_CLOSE  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_VIOLATION = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // What each cell does while the token passes it
    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_PLACE  = 2'd1,
        OP_UNLOCK = 2'd2,
        OP_CLOSE  = 2'd3
    } t_op;

    // Request held stable for each walk of the chain and broadcast to every cell
    typedef struct packed {
        t_op               op;
        logic              any_owner;
        logic [OWNER_W-1:0] owner;
        logic [KEY_W-1:0]   key;
        logic [ADDR_W-1:0]  lo;
        logic [ADDR_W-1:0]  hi;
    } t_req;

    // Token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
    } t_tok;

endpackage

/* hw/rtl/brlt_cell.sv */
// One lock entry of the chain: holds the entry, tests it against the request
// and hands the token on. Depends on brlt_pkg.
`timescale 1ns / 1ps

module brlt_cell #(
    parameter int HANDLE_W = brlt_pkg::HANDLE_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  brlt_pkg::t_req       i_req,
    input  logic [HANDLE_W-1:0]  i_handle,
    input  brlt_pkg::t_tok       i_tok,
    output brlt_pkg::t_tok       o_tok
);
    import brlt_pkg::*;

    logic                r_used;
    logic [ADDR_W-1:0]   r_start;
    logic [ADDR_W-1:0]   r_end;
    logic [HANDLE_W-1:0] r_handle;
    logic [KEY_W-1:0]    r_key;
    logic [OWNER_W-1:0]  r_owner;
    t_tok                r_tok;

    logic n_used;
    logic n_write;
    t_tok n_tok;
    logic w_conflict;
    logic w_exact;
    logic w_same_handle;

    always_comb begin
        w_conflict = r_used
                  && (i_req.any_owner || r_owner != i_req.owner)
                  && r_key == i_req.key
                  && ((i_req.lo >= r_start && i_req.lo < r_end)
                   || (i_req.hi > r_start && i_req.hi <= r_end));
        w_exact = r_used && r_owner == i_req.owner && r_handle == i_handle
               && r_start == i_req.lo && r_end == i_req.hi;
        w_same_handle = r_used && r_handle == i_handle;
    end

    always_comb begin
        n_tok   = i_tok;
        n_used  = r_used;
        n_write = 1'b0;
        if (i_tok.valid) begin
            case (i_req.op)
                OP_CHECK: begin
                    if (w_conflict) n_tok.hit = 1'b1;
                end
                OP_PLACE: begin
                    // first free entry takes the lock
                    if (!r_used && !i_tok.hit) begin
                        n_tok.hit = 1'b1;
                        n_used    = 1'b1;
                        n_write   = 1'b1;
                    end
                end
                OP_UNLOCK: begin
                    if (w_exact && !i_tok.hit) begin
                        n_tok.hit = 1'b1;
                        n_used    = 1'b0;
                    end
                end
                OP_CLOSE: begin
                    if (w_same_handle) n_used = 1'b0;
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_used <= n_used;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_write) begin
            r_start  <= i_req.lo;
            r_end    <= i_req.hi;
            r_handle <= i_handle;
            r_key    <= i_req.key;
            r_owner  <= i_req.owner;
        end
    end

    assign o_tok = r_tok;

endmodule

/* hw/rtl/byte_range_lock_table.sv */
// Top level of the byte-range lock table: request decode, control and the
// chain of entry cells. Depends on brlt_pkg and brlt_cell.
`timescale 1ns / 1ps

// Byte-range lock table.
// A request is transferred when start is high and busy is low. Every request
// gives one result, shown on o_status / o_critical_error for one cycle with
// o_done high; the receiver always takes it and cannot stall the block.
// Requests run one at a time. The entries sit in a chain of LOCK_ENTRIES
// cells; a token walks the chain one cell per cycle and each cell tests or
// updates its own entry as the token passes.
// An access check, unlock, close or refused lock walks the chain once; a
// granted or table-full lock walks it a second time to claim a free entry.
// A zero-length access, lock or unlock, or a lock, unlock or close whose
// handle is out of range, gives its result with no walk.
// busy drops with the result, so the next request can be transferred at the
// edge that ends the result cycle.
// Reset empties the table (all entries free) and returns to idle; entry
// contents are written only when a lock is granted.
module byte_range_lock_table #(
    parameter int  LOCK_ENTRIES = brlt_pkg::LOCK_ENTRIES_DEF,
    parameter int  FILE_HANDLES = brlt_pkg::FILE_HANDLES_DEF,
    localparam int HANDLE_W     = (FILE_HANDLES > 1) ? $clog2(FILE_HANDLES) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_req_type,
    input  logic [brlt_pkg::OWNER_W-1:0] i_owner_id,
    input  logic [HANDLE_W-1:0]          i_file_handle,
    input  logic [brlt_pkg::KEY_W-1:0]   i_file_key,
    input  logic [brlt_pkg::ADDR_W-1:0]  i_offset,
    input  logic [brlt_pkg::ADDR_W-1:0]  i_length,
    input  logic                         i_allow_critical,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic                         o_critical_error
);
    import brlt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic                r_is_lock, n_is_lock;
    logic                r_allow_crit, n_allow_crit;
    logic                r_launch, n_launch;
    logic                r_done, n_done;
    t_status             r_status, n_status;
    logic                r_crit, n_crit;

    logic                w_accept;
    logic [ADDR_W:0]     w_sum;
    logic [ADDR_W-1:0]   w_hi;
    logic                w_zero_len;
    logic                w_handle_ok;
    t_tok                w_tok [LOCK_ENTRIES+1];
    t_tok                w_last;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // end of range saturates at all ones
    assign w_sum       = {1'b0, i_offset} + {1'b0, i_length};
    assign w_hi        = w_sum[ADDR_W] ? '1 : w_sum[ADDR_W-1:0];
    assign w_zero_len  = (w_hi == i_offset);
    assign w_handle_ok = {1'b0, i_file_handle} < (HANDLE_W+1)'(FILE_HANDLES);

    assign w_tok[0] = '{valid: r_launch, hit: 1'b0};
    assign w_last   = w_tok[LOCK_ENTRIES];

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_handle     = r_handle;
        n_is_lock    = r_is_lock;
        n_allow_crit = r_allow_crit;
        n_launch     = 1'b0;
        n_done       = 1'b0;
        n_status     = r_status;
        n_crit       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req.any_owner = (t_req_type'(i_req_type) == REQ_LOCK)
                                   || (i_owner_id == '0);
                    n_req.owner  = i_owner_id;
                    n_req.key    = i_file_key;
                    n_req.lo     = i_offset;
                    n_req.hi     = w_hi;
                    n_handle     = i_file_handle;
                    n_allow_crit = i_allow_critical;
                    n_is_lock    = (t_req_type'(i_req_type) == REQ_LOCK);
                    n_status     = ST_OK;
                    case (t_req_type'(i_req_type))
                        REQ_CLOSE: begin
                            n_req.op = OP_CLOSE;
                            n_launch = w_handle_ok;
                        end
                        REQ_ACCESS: begin
                            n_req.op = OP_CHECK;
                            n_launch = !w_zero_len;
                        end
                        REQ_LOCK: begin
                            n_req.op = OP_CHECK;
                            n_launch = !w_zero_len && w_handle_ok;
                            if (!w_zero_len && !w_handle_ok) n_status = ST_VIOLATION;
                        end
                        REQ_UNLOCK: begin
                            n_req.op = OP_UNLOCK;
                            n_launch = !w_zero_len && w_handle_ok;
                            if (!w_zero_len && !w_handle_ok) n_status = ST_VIOLATION;
                        end
                        default: begin
                            n_req.op = OP_CHECK;
                        end
                    endcase
                    if (n_launch) n_state = S_SCAN;
                    else          n_done  = 1'b1;
                end
            end
            S_SCAN: begin
                if (w_last.valid) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    case (r_req.op)
                        OP_CHECK: begin
                            if (r_is_lock && !w_last.hit) begin
                                // no conflict: walk again to claim a free entry
                                n_req.op = OP_PLACE;
                                n_launch = 1'b1;
                                n_done   = 1'b0;
                                n_state  = S_SCAN;
                            end else begin
                                n_status = w_last.hit ? ST_VIOLATION : ST_OK;
                                n_crit   = w_last.hit && r_allow_crit && !r_is_lock;
                            end
                        end
                        OP_PLACE:  n_status = w_last.hit ? ST_OK : ST_FULL;
                        OP_UNLOCK: n_status = w_last.hit ? ST_OK : ST_VIOLATION;
                        OP_CLOSE:  n_status = ST_OK;
                        default:   n_status = ST_OK;
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_done   <= 1'b0;
            r_crit   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_done   <= n_done;
            r_crit   <= n_crit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_handle     <= n_handle;
        r_is_lock    <= n_is_lock;
        r_allow_crit <= n_allow_crit;
        r_status     <= n_status;
    end

    for (genvar g = 0; g < LOCK_ENTRIES; g++) begin : g_cell
        brlt_cell #(
            .HANDLE_W (HANDLE_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_req    (r_req),
            .i_handle (r_handle),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1])
        );
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_critical_error = r_crit;

endmodule

/* hw/rtl/brlt_checker.sv */
// Port-level checks for the byte-range lock table, bound to the top level.
// Depends on brlt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brlt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic       o_critical_error
);
    import brlt_pkg::*;

    // critical error comes only with a violation
    `ASSERT_CLK(a_crit_with_violation, i_clk, i_rst_n, o_done && o_critical_error |-> o_status == ST_VIOLATION)

    // a result follows a transfer or the end of a walk
    `ASSERT_CLK(a_done_has_cause, i_clk, i_rst_n, o_done |-> $past(start) || $past(busy))

    // the block is idle whenever a result is shown
    `ASSERT_NEVER(a_done_while_busy, i_clk, i_rst_n, o_done && busy)

    // leaving a walk always produces a result
    `ASSERT_CLK(a_busy_ends_with_done, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n) |-> o_done)

endmodule

bind byte_range_lock_table brlt_checker u_brlt_checker (.*);

/* dv/tb_byte_range_lock_table.sv */
// Testbench for byte_range_lock_table: directed and random requests checked
// against an in-bench table predictor. Depends on brlt_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_byte_range_lock_table;
    import brlt_pkg::*;

    localparam int N_ENTRIES  = 32;
    localparam int RAND_ITEMS = 1030;

    typedef struct {
        t_req_type   kind;
        logic [15:0] owner;
        logic [3:0]  handle;
        logic [15:0] key;
        logic [31:0] offset;
        logic [31:0] length;
        logic        allow_crit;
    } t_lock_req;

    typedef struct {
        t_status status;
        logic    crit;
    } t_lock_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic [15:0] i_owner_id = '0;
    logic [3:0]  i_file_handle = '0;
    logic [15:0] i_file_key = '0;
    logic [31:0] i_offset = '0;
    logic [31:0] i_length = '0;
    logic        i_allow_critical = 1'b0;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_critical_error;

    byte_range_lock_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_owner_id       (i_owner_id),
        .i_file_handle    (i_file_handle),
        .i_file_key       (i_file_key),
        .i_offset         (i_offset),
        .i_length         (i_length),
        .i_allow_critical (i_allow_critical),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_critical_error (o_critical_error)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Shadow copy of the lock table
    logic        tbl_used   [N_ENTRIES] = '{default: 1'b0};
    logic [31:0] tbl_lo     [N_ENTRIES];
    logic [31:0] tbl_hi     [N_ENTRIES];
    logic [3:0]  tbl_handle [N_ENTRIES];
    logic [15:0] tbl_key    [N_ENTRIES];
    logic [15:0] tbl_owner  [N_ENTRIES];

    t_lock_req  pend_q[$];
    t_lock_req  lock_hist[$];
    t_lock_resp resp_q[$];
    t_lock_req  drv_item;
    logic       item_taken = 1'b0;
    int         idle_left = 0;
    int         drv_count = 0;
    int         err_count = 0;
    int         kind_cnt[4] = '{default: 0};
    int         stat_cnt[3] = '{default: 0};
    int         crit_cnt = 0;

    // Used entry of another owner (or any owner when owner is 0) on the same
    // key whose range holds lo or the end point hi.
    function automatic logic range_taken(input logic [15:0] owner, input logic [15:0] key,
                                         input logic [31:0] lo, input logic [31:0] hi);
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (tbl_used[i] && !(owner != 0 && tbl_owner[i] == owner) && tbl_key[i] == key &&
                ((lo >= tbl_lo[i] && lo < tbl_hi[i]) || (hi > tbl_lo[i] && hi <= tbl_hi[i])))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_request(input t_lock_req r, output t_status st, output logic crit);
        logic [32:0] sum;
        logic [31:0] hi;
        logic [31:0] len;
        int          slot;
        st   = ST_OK;
        crit = 1'b0;
        slot = -1;
        sum  = {1'b0, r.offset} + {1'b0, r.length};
        hi   = sum[31:0];
        len  = r.length;
        if (sum[32]) begin
            hi  = 32'hFFFF_FFFF;
            len = 32'hFFFF_FFFF - r.offset;
        end
        // 4-bit handle is always inside the 16-entry handle space
        if (r.kind == REQ_CLOSE) begin
            for (int i = 0; i < N_ENTRIES; i++)
                if (tbl_used[i] && tbl_handle[i] == r.handle) tbl_used[i] = 1'b0;
        end else if (len != 0) begin
            case (r.kind)
                REQ_ACCESS: begin
                    if (range_taken(r.owner, r.key, r.offset, hi)) begin
                        st   = ST_VIOLATION;
                        crit = r.allow_crit;
                    end
                end
                REQ_LOCK: begin
                    if (range_taken(16'd0, r.key, r.offset, hi)) begin
                        st = ST_VIOLATION;
                    end else begin
                        for (int i = 0; i < N_ENTRIES && slot < 0; i++)
                            if (!tbl_used[i]) slot = i;
                        if (slot < 0) begin
                            st = ST_FULL;
                        end else begin
                            tbl_used[slot]   = 1'b1;
                            tbl_lo[slot]     = r.offset;
                            tbl_hi[slot]     = hi;
                            tbl_handle[slot] = r.handle;
                            tbl_key[slot]    = r.key;
                            tbl_owner[slot]  = r.owner;
                        end
                    end
                end
                default: begin
                    st = ST_VIOLATION;
                    for (int i = 0; i < N_ENTRIES && st != ST_OK; i++) begin
                        if (tbl_used[i] && tbl_owner[i] == r.owner && tbl_handle[i] == r.handle &&
                            tbl_lo[i] == r.offset && tbl_hi[i] == hi) begin
                            tbl_used[i] = 1'b0;
                            st = ST_OK;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic add_req(input t_req_type kind, input logic [15:0] owner,
                           input logic [3:0] handle, input logic [15:0] key,
                           input logic [31:0] offset, input logic [31:0] length,
                           input logic allow_crit);
        t_lock_req r;
        r = '{kind, owner, handle, key, offset, length, allow_crit};
        pend_q.push_back(r);
        if (kind == REQ_LOCK) begin
            lock_hist.push_back(r);
            if (lock_hist.size() > 64) void'(lock_hist.pop_front());
        end
    endtask

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_FF00 + $urandom_range(0, 255);
            default: return $urandom_range(0, 63) * 16 + $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 96);
        endcase
    endfunction

    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic logic [15:0] pick_owner();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    // Request driver: start held until the transfer, then a random idle gap, possibly empty
    always @(negedge i_clk) begin : drive_p
        t_lock_req nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !item_taken) begin
            // waiting for busy to drop
        end else begin
            item_taken = 1'b0;
            if (idle_left != 0) begin
                start <= 1'b0;
                if (!busy) idle_left--;
            end else if (pend_q.size() != 0) begin
                nxt = pend_q.pop_front();
                drv_item = nxt;
                i_req_type       <= nxt.kind;
                i_owner_id       <= nxt.owner;
                i_file_handle    <= nxt.handle;
                i_file_key       <= nxt.key;
                i_offset         <= nxt.offset;
                i_length         <= nxt.length;
                i_allow_critical <= nxt.allow_crit;
                start <= 1'b1;
                // every third stretch of 48 items runs back to back
                idle_left = ((drv_count / 48) % 3 == 2) ? 0 : $urandom_range(0, 3);
                drv_count++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result check, then prediction for a request transferred at this edge
    always @(posedge i_clk) begin : watch_p
        t_lock_resp want;
        t_status    st;
        logic       crit;
        if (i_rst_n) begin
            if (o_done !== 1'b0) begin
                if (resp_q.size() == 0) begin
                    err_count++;
                    $display("%0t: result with none pending, status %0d critical %0d",
                             $time, o_status, o_critical_error);
                end else begin
                    want = resp_q.pop_front();
                    if (o_status !== want.status) begin
                        err_count++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, o_status);
                    end
                    if (o_critical_error !== want.crit) begin
                        err_count++;
                        $display("%0t: critical_error mismatch, expected %0d actual %0d",
                                 $time, want.crit, o_critical_error);
                    end
                end
            end
            if (start && !busy) begin
                predict_request(drv_item, st, crit);
                resp_q.push_back('{st, crit});
                kind_cnt[drv_item.kind]++;
                stat_cnt[st]++;
                if (crit) crit_cnt++;
                item_taken = 1'b1;
            end
        end
    end

    initial begin : stim_p
        t_lock_req h;
        int        n_rand;
        n_rand = 0;

        // Directed: overlap edges, saturation, zero length, owner 0, close
        add_req(REQ_ACCESS, 16'd1, 4'd2, 16'h0010, 32'd100, 32'd50, 1'b1);
        add_req(REQ_LOCK,   16'd1, 4'd2, 16'h0010, 32'd100, 32'd50, 1'b0);
        add_req(REQ_ACCESS, 16'd2, 4'd0, 16'h0010, 32'd120, 32'd5,  1'b1);
        add_req(REQ_ACCESS, 16'd2, 4'd0, 16'h0010, 32'd120, 32'd5,  1'b0);
        add_req(REQ_ACCESS, 16'd1, 4'd0, 16'h0010, 32'd120, 32'd5,  1'b1);
        add_req(REQ_ACCESS, 16'd0, 4'd0, 16'h0010, 32'd149, 32'd1,  1'b1);
        add_req(REQ_ACCESS, 16'd2, 4'd0, 16'h0011, 32'd120, 32'd5,  1'b1);
        add_req(REQ_ACCESS, 16'd2, 4'd0, 16'h0010, 32'd50,  32'd200, 1'b1);
        add_req(REQ_ACCESS, 16'd2, 4'd0, 16'h0010, 32'd90,  32'd11, 1'b1);
        add_req(REQ_ACCESS, 16'd2, 4'd0, 16'h0010, 32'd150, 32'd10, 1'b1);
        add_req(REQ_LOCK,   16'd1, 4'd2, 16'h0010, 32'd140, 32'd20, 1'b0);
        add_req(REQ_LOCK,   16'd1, 4'd2, 16'h0010, 32'd140, 32'd0,  1'b0);
        add_req(REQ_LOCK,   16'hFFFF, 4'd15, 16'hFFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1);
        add_req(REQ_ACCESS, 16'd0, 4'd15, 16'hFFFF, 32'hFFFF_FFFE, 32'd1, 1'b1);
        add_req(REQ_ACCESS, 16'd0, 4'd15, 16'hFFFF, 32'hFFFF_FFFF, 32'd1, 1'b1);
        add_req(REQ_UNLOCK, 16'hFFFF, 4'd15, 16'hFFFF, 32'hFFFF_FF00, 32'd255, 1'b0);
        add_req(REQ_UNLOCK, 16'hFFFF, 4'd15, 16'hFFFF, 32'hFFFF_FF00, 32'd255, 1'b0);
        add_req(REQ_UNLOCK, 16'd1, 4'd2, 16'h0010, 32'd100, 32'd0,  1'b0);
        add_req(REQ_UNLOCK, 16'd1, 4'd3, 16'h0010, 32'd100, 32'd50, 1'b0);
        add_req(REQ_CLOSE,  16'd1, 4'd2, 16'h0010, 32'd0,   32'd0,  1'b0);
        add_req(REQ_ACCESS, 16'd0, 4'd0, 16'h0010, 32'd100, 32'd50, 1'b1);
        add_req(REQ_LOCK,   16'd0, 4'd0, 16'h0000, 32'd0,   32'd1,  1'b0);
        add_req(REQ_ACCESS, 16'd5, 4'd0, 16'h0000, 32'd0,   32'hFFFF_FFFF, 1'b1);
        add_req(REQ_CLOSE,  16'd0, 4'd15, 16'h0000, 32'd0,  32'd0,  1'b0);
        add_req(REQ_CLOSE,  16'd0, 4'd0,  16'h0000, 32'd0,  32'd0,  1'b0);

        while (n_rand < RAND_ITEMS) begin
            if (n_rand % 200 == 150) begin
                // fill the table past its size with disjoint ranges, then empty it
                h.key = 16'($urandom);
                for (int k = 0; k < N_ENTRIES + 3; k++)
                    add_req(REQ_LOCK, pick_owner(), 4'($urandom_range(0, 15)), h.key,
                            k * 256, 32'd128, 1'($urandom));
                for (int k = 0; k < 16; k++)
                    add_req(REQ_CLOSE, 16'($urandom), 4'(k), 16'($urandom), $urandom,
                            $urandom, 1'($urandom));
                n_rand += N_ENTRIES + 19;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: add_req(REQ_LOCK, pick_owner(), 4'($urandom_range(0, 15)),
                                 pick_key(), pick_offset(), pick_length(), 1'($urandom));
                3, 4: add_req(REQ_ACCESS, ($urandom_range(0, 3) == 0) ? 16'd0 : pick_owner(),
                              4'($urandom), pick_key(), pick_offset(), pick_length(),
                              1'($urandom));
                5, 6, 7: begin
                    if (lock_hist.size() != 0 && $urandom_range(0, 4) != 0) begin
                        h = lock_hist[$urandom_range(0, lock_hist.size() - 1)];
                        // occasionally near-miss on one field
                        case ($urandom_range(0, 9))
                            0:       h.length = h.length + 32'd1;
                            1:       h.handle = h.handle ^ 4'd1;
                            2:       h.owner  = h.owner + 16'd1;
                            default: ;
                        endcase
                        add_req(REQ_UNLOCK, h.owner, h.handle, h.key, h.offset, h.length,
                                1'($urandom));
                    end else begin
                        add_req(REQ_UNLOCK, pick_owner(), 4'($urandom), pick_key(),
                                pick_offset(), pick_length(), 1'($urandom));
                    end
                end
                default: add_req(REQ_CLOSE, 16'($urandom), 4'($urandom), 16'($urandom),
                                 $urandom, $urandom, 1'($urandom));
            endcase
            n_rand++;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || start) @(posedge i_clk);
        while (resp_q.size() != 0) @(posedge i_clk);
        // longest request is two walks of the chain
        repeat (2 * N_ENTRIES + 16) @(posedge i_clk);

        $display("Ran %0d requests: %0d access checks, %0d locks, %0d unlocks, %0d closes",
                 drv_count, kind_cnt[REQ_ACCESS], kind_cnt[REQ_LOCK], kind_cnt[REQ_UNLOCK],
                 kind_cnt[REQ_CLOSE]);
        $display("Outcomes: %0d ok, %0d violations, %0d table full, %0d critical errors",
                 stat_cnt[ST_OK], stat_cnt[ST_VIOLATION], stat_cnt[ST_FULL], crit_cnt);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : timeout_p
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
